// ===== hdl/jdc_pkg.sv =====
// package: item types, calendar constants and tables for the julian day converter
package jdc_pkg;

  localparam int NUM_STAGES = 12;

  localparam int unsigned JD_EPOCH  = 1721119;
  localparam int unsigned JD_MIN    = 1721426;
  localparam int unsigned JD_MAX    = 5373484;
  localparam int unsigned DAYS_400Y = 146097;
  localparam int unsigned DAYS_4Y   = 1461;
  localparam int unsigned DAYS_5MON = 153;
  localparam int unsigned CENT_YRS  = 100;

  // reciprocals for the constant divisions, each estimate is low by at most one
  localparam int unsigned RECIP_400Y   = 14699;   // 2^31 / 146097
  localparam int unsigned RECIP_4Y     = 183734;  // 2^28 / 1461
  localparam int unsigned RECIP_5MON   = 428;     // 2^16 / 153
  localparam int unsigned RECIP_CENT   = 5243;    // 2^19 / 100, exact for 14-bit years
  localparam int unsigned RECIP_FIVE   = 205;     // 2^10 / 5, exact below 160

  localparam logic       REQ_TO_JD   = 1'b0;
  localparam logic       REQ_TO_DATE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [13:0] in_year;
    logic [22:0] in_day_number;
  } jdc_in_t;

  typedef struct packed {
    logic [22:0] out_day_number;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic        out_of_range;
  } jdc_out_t;

  // days before month index mi, counted from march
  function automatic logic [8:0] month_days(input logic [3:0] mi);
    logic [8:0] res;
    unique case (mi)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      4'd12:   res = 9'd367;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/jdc_fwd_path.sv =====
// datapath: date to julian day number, seven compute stages then a delay line
module jdc_fwd_path (
  input  logic                                clk,
  input  logic [jdc_pkg::NUM_STAGES-1:0]      ld,
  input  logic [4:0]                          day,
  input  logic [3:0]                          month,
  input  logic [13:0]                         year,
  output logic [22:0]                         day_number
);

  logic [13:0] y_fix;
  logic [13:0] yr1, yr2, yr3;
  logic [3:0]  mi1, mi2, mi3, mi4;
  logic [4:0]  d1, d2, d3, d4, d5;
  logic [7:0]  cent2;
  logic [26:0] cent_prod;
  logic [14:0] p3;
  logic [25:0] cdays_prod;
  logic [23:0] cdays3, cdays4, cdays5;
  logic [6:0]  yic4;
  logic [17:0] ydays_prod;
  logic [15:0] ydays5;
  logic [8:0]  mdays5;
  logic [23:0] sum1_6;
  logic [21:0] sum2_6;
  logic [22:0] line [7:12];

  assign y_fix      = (year == 14'd0) ? 14'd1 : year;
  assign cent_prod  = 27'(yr1) * 27'(jdc_pkg::RECIP_CENT);
  assign cdays_prod = 26'(cent2) * 26'(jdc_pkg::DAYS_400Y);
  assign ydays_prod = 18'(yic4) * 18'(jdc_pkg::DAYS_4Y);

  always_ff @(posedge clk) begin
    // stage 1: shift january and february to the previous year
    if (ld[0]) begin
      d1 <= day;
      if (month > 4'd2) begin
        mi1 <= month - 4'd3;
        yr1 <= y_fix;
      end else begin
        mi1 <= month + 4'd9;
        yr1 <= y_fix - 14'd1;
      end
    end
    // stage 2: century by reciprocal
    if (ld[1]) begin
      cent2 <= cent_prod[26:19];
      yr2   <= yr1;
      mi2   <= mi1;
      d2    <= d1;
    end
    // stage 3: days of whole centuries
    if (ld[2]) begin
      p3     <= 15'(cent2) * 15'(jdc_pkg::CENT_YRS);
      cdays3 <= cdays_prod[25:2];
      yr3    <= yr2;
      mi3    <= mi2;
      d3     <= d2;
    end
    // stage 4: year within century
    if (ld[3]) begin
      yic4   <= 7'(15'(yr3) - p3);
      cdays4 <= cdays3;
      mi4    <= mi3;
      d4     <= d3;
    end
    // stage 5: days of years and months
    if (ld[4]) begin
      ydays5 <= ydays_prod[17:2];
      mdays5 <= jdc_pkg::month_days(mi4);
      cdays5 <= cdays4;
      d5     <= d4;
    end
    // stage 6: partial sums
    if (ld[5]) begin
      sum1_6 <= cdays5 + 24'(ydays5);
      sum2_6 <= 22'(mdays5) + 22'(d5) + 22'(jdc_pkg::JD_EPOCH);
    end
    // stage 7: total
    if (ld[6]) begin
      line[7] <= 23'(sum1_6 + 24'(sum2_6));
    end
    for (int k = 8; k <= jdc_pkg::NUM_STAGES; k++) begin
      if (ld[k-1]) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign day_number = line[jdc_pkg::NUM_STAGES];

endmodule

// ===== hdl/jdc_rev_path.sv =====
// datapath: julian day number to date in twelve stages
module jdc_rev_path (
  input  logic                                clk,
  input  logic [jdc_pkg::NUM_STAGES-1:0]      ld,
  input  logic [22:0]                         day_number,
  output logic [4:0]                          day,
  output logic [3:0]                          month,
  output logic [13:0]                         year,
  output logic                                out_of_range
);

  logic [23:0] t0, n0;
  logic        oor [1:12];
  logic [23:0] n1, n2, n3;
  logic [37:0] q_prod;
  logic [6:0]  q2, q3;
  logic [24:0] p3;
  logic [24:0] r4_lo;
  logic [25:0] r4_hi;
  logic [17:0] r4;
  logic [6:0]  cent4, cent5, cent6, cent7;
  logic [17:0] m5_comb, m5, m6;
  logic [35:0] y_prod;
  logic [7:0]  yq5, yq6;
  logic [18:0] p6;
  logic [18:0] r7_lo;
  logic [19:0] r7_hi;
  logic [7:0]  yic7;
  logic [10:0] dd7;
  logic [11:0] dd8_sum;
  logic [9:0]  dd8;
  logic [11:0] x8, x9, x10;
  logic [13:0] yb8, yb9, yb10, yb11;
  logic [20:0] m_prod;
  logic [4:0]  mq9, mq10;
  logic [12:0] p10;
  logic [12:0] r11_lo;
  logic [13:0] r11_hi;
  logic [4:0]  mi11;
  logic [7:0]  rm11;
  logic [16:0] d_prod;
  logic [4:0]  day12;
  logic [3:0]  mon12;
  logic [13:0] yr12;

  assign t0 = {1'b0, day_number} - 24'(jdc_pkg::JD_EPOCH);
  assign n0 = {t0[21:0], 2'b00} - 24'd1;

  assign q_prod  = 38'(n1) * 38'(jdc_pkg::RECIP_400Y);
  assign r4_lo   = {1'b0, n3} - p3;
  assign r4_hi   = {1'b0, r4_lo} - 26'(jdc_pkg::DAYS_400Y);
  assign m5_comb = {r4[17:2], 2'b11};
  assign y_prod  = 36'(m5_comb) * 36'(jdc_pkg::RECIP_4Y);
  assign r7_lo   = {1'b0, m6} - p6;
  assign r7_hi   = {1'b0, r7_lo} - 20'(jdc_pkg::DAYS_4Y);
  assign dd8_sum = 12'(dd7) + 12'd4;
  assign dd8     = dd8_sum[11:2];
  assign m_prod  = 21'(x8) * 21'(jdc_pkg::RECIP_5MON);
  assign r11_lo  = {1'b0, x10} - p10;
  assign r11_hi  = {1'b0, r11_lo} - 14'(jdc_pkg::DAYS_5MON);
  assign d_prod  = 17'(9'(rm11) + 9'd5) * 17'(jdc_pkg::RECIP_FIVE);

  always_ff @(posedge clk) begin
    // stage 1: offset from epoch, range check
    if (ld[0]) begin
      n1     <= n0;
      oor[1] <= (day_number < 23'(jdc_pkg::JD_MIN)) || (day_number > 23'(jdc_pkg::JD_MAX));
    end
    for (int k = 2; k <= jdc_pkg::NUM_STAGES; k++) begin
      if (ld[k-1]) begin
        oor[k] <= oor[k-1];
      end
    end
    // stage 2: century estimate
    if (ld[1]) begin
      q2 <= q_prod[37:31];
      n2 <= n1;
    end
    // stage 3: back-multiply
    if (ld[2]) begin
      p3 <= 25'(q2) * 25'(jdc_pkg::DAYS_400Y);
      q3 <= q2;
      n3 <= n2;
    end
    // stage 4: remainder with one-step correction
    if (ld[3]) begin
      if (!r4_hi[25]) begin
        cent4 <= q3 + 7'd1;
        r4    <= 18'(r4_hi);
      end else begin
        cent4 <= q3;
        r4    <= 18'(r4_lo);
      end
    end
    // stage 5: year-in-century estimate
    if (ld[4]) begin
      yq5   <= y_prod[35:28];
      m5    <= m5_comb;
      cent5 <= cent4;
    end
    // stage 6: back-multiply
    if (ld[5]) begin
      p6    <= 19'(yq5) * 19'(jdc_pkg::DAYS_4Y);
      yq6   <= yq5;
      m6    <= m5;
      cent6 <= cent5;
    end
    // stage 7: remainder with correction
    if (ld[6]) begin
      if (!r7_hi[19]) begin
        yic7 <= yq6 + 8'd1;
        dd7  <= 11'(r7_hi);
      end else begin
        yic7 <= yq6;
        dd7  <= 11'(r7_lo);
      end
      cent7 <= cent6;
    end
    // stage 8: day of year to month numerator, base year
    if (ld[7]) begin
      x8  <= 12'(12'(dd8) * 12'd5 - 12'd3);
      yb8 <= 14'(cent7) * 14'(jdc_pkg::CENT_YRS) + 14'(yic7);
    end
    // stage 9: month estimate
    if (ld[8]) begin
      mq9 <= m_prod[20:16];
      x9  <= x8;
      yb9 <= yb8;
    end
    // stage 10: back-multiply
    if (ld[9]) begin
      p10  <= 13'(mq9) * 13'(jdc_pkg::DAYS_5MON);
      mq10 <= mq9;
      x10  <= x9;
      yb10 <= yb9;
    end
    // stage 11: remainder with correction
    if (ld[10]) begin
      if (!r11_hi[13]) begin
        mi11 <= mq10 + 5'd1;
        rm11 <= 8'(r11_hi);
      end else begin
        mi11 <= mq10;
        rm11 <= 8'(r11_lo);
      end
      yb11 <= yb10;
    end
    // stage 12: day, month from march index, year carry for jan and feb
    if (ld[11]) begin
      day12 <= d_prod[14:10];
      if (mi11 < 5'd10) begin
        mon12 <= 4'(mi11 + 5'd3);
        yr12  <= yb11;
      end else begin
        mon12 <= 4'(mi11 - 5'd9);
        yr12  <= yb11 + 14'd1;
      end
    end
  end

  assign day          = day12;
  assign month        = mon12;
  assign year         = yr12;
  assign out_of_range = oor[jdc_pkg::NUM_STAGES];

endmodule

// ===== hdl/julian_day_converter.sv =====
// top level: pipelined gregorian date <-> julian day number converter
//
// Converts in both directions with integer arithmetic only. A req item with
// req_type 0 turns in_day, in_month, in_year into a julian day number (year 0
// is taken as year 1, january and february belong to the previous year). With
// req_type 1 it turns in_day_number into day, month and year; numbers outside
// 1721426..5373484 set out_of_range and give zero date fields. Every req item
// yields exactly one rsp item, in order. The block is a 12-stage pipeline that
// takes one item per clock unless rsp_stall holds it. The stage count comes
// from the three constant divisions of the reverse path (400-year, 4-year and
// 5-month cycles), each done as reciprocal multiply, back-multiply and a
// one-step remainder correction in separate stages. rsp_stall holds the
// pipeline only where a stage is full and the one after it cannot move, so
// empty slots are squeezed out and req_stall rises only when all is full.
module julian_day_converter (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  jdc_pkg::jdc_in_t  req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output jdc_pkg::jdc_out_t rsp
);

  // per-stage item valid and load enable
  logic [jdc_pkg::NUM_STAGES-1:0] vld;
  logic [jdc_pkg::NUM_STAGES-1:0] ld;
  // request type travels alongside the datapaths
  logic [jdc_pkg::NUM_STAGES-1:0] kind;

  logic [22:0] fwd_jd;
  logic [4:0]  rev_day;
  logic [3:0]  rev_month;
  logic [13:0] rev_year;
  logic        rev_oor;
  logic        is_rev;

  // a stage may load when it is empty or its contents move on
  always_comb begin
    ld[jdc_pkg::NUM_STAGES-1] = !vld[jdc_pkg::NUM_STAGES-1] || !rsp_stall;
    for (int k = jdc_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign req_stall = !ld[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= req_valid;
      end
      for (int k = 1; k < jdc_pkg::NUM_STAGES; k++) begin
        if (ld[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      kind[0] <= req.req_type;
    end
    for (int k = 1; k < jdc_pkg::NUM_STAGES; k++) begin
      if (ld[k]) begin
        kind[k] <= kind[k-1];
      end
    end
  end

  jdc_fwd_path u_fwd (
    .clk        (clk),
    .ld         (ld),
    .day        (req.in_day),
    .month      (req.in_month),
    .year       (req.in_year),
    .day_number (fwd_jd)
  );

  jdc_rev_path u_rev (
    .clk          (clk),
    .ld           (ld),
    .day_number   (req.in_day_number),
    .day          (rev_day),
    .month        (rev_month),
    .year         (rev_year),
    .out_of_range (rev_oor)
  );

  // last stage registers feed the rsp item; zero the fields the request did not ask for
  assign is_rev    = (kind[jdc_pkg::NUM_STAGES-1] == jdc_pkg::REQ_TO_DATE);
  assign rsp_valid = vld[jdc_pkg::NUM_STAGES-1];

  always_comb begin
    rsp.out_day_number = is_rev ? 23'd0 : fwd_jd;
    rsp.out_of_range   = is_rev && rev_oor;
    rsp.out_day        = (is_rev && !rev_oor) ? rev_day : 5'd0;
    rsp.out_month      = (is_rev && !rev_oor) ? rev_month : 4'd0;
    rsp.out_year       = (is_rev && !rev_oor) ? rev_year : 14'd0;
  end

endmodule

// ===== tb/sv/jdc_checker.sv =====
// checker: watches both channels of the julian day converter, predicts and compares
`timescale 1ns / 1ps

module jdc_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  jdc_pkg::jdc_in_t  req,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  jdc_pkg::jdc_out_t rsp,
  output int                outstanding,
  output int                fail_count
);

  localparam logic [31:0] EPOCH     = 32'd1721119;
  localparam logic [31:0] CYCLE_400 = 32'd146097;
  localparam logic [31:0] CYCLE_4   = 32'd1461;
  localparam logic [31:0] CYCLE_5M  = 32'd153;
  localparam logic [31:0] CENTURY   = 32'd100;

  jdc_pkg::jdc_out_t awaited_conversions[$];
  int                errs = 0;

  // march-based year, so january and february belong to the year before
  function automatic logic [31:0] days_from_date(logic [31:0] d, logic [31:0] m,
                                                 logic [31:0] y);
    logic [31:0] yr, mi, cent, yic;
    if (y < 1) y = 1;
    if (m > 2) begin
      mi = m - 3;
      yr = y;
    end else begin
      mi = m + 9;
      yr = y - 1;
    end
    cent = yr / CENTURY;
    yic  = yr - CENTURY * cent;
    return (CYCLE_400 * cent) / 4 + (CYCLE_4 * yic) / 4 + (CYCLE_5M * mi + 2) / 5 + d + EPOCH;
  endfunction

  function automatic void date_from_days(input logic [31:0] jd, output logic [31:0] d,
                                         output logic [31:0] m, output logic [31:0] y);
    logic [31:0] t, cent, yic, mi, dd;
    t    = jd - EPOCH;
    cent = (4 * t - 1) / CYCLE_400;
    t    = 4 * t - 1 - CYCLE_400 * cent;
    dd   = t / 4;
    yic  = (4 * dd + 3) / CYCLE_4;
    dd   = 4 * dd + 3 - CYCLE_4 * yic;
    dd   = (dd + 4) / 4;
    mi   = (5 * dd - 3) / CYCLE_5M;
    dd   = 5 * dd - 3 - CYCLE_5M * mi;
    dd   = (dd + 5) / 5;
    t    = CENTURY * cent + yic;
    if (mi < 10) begin
      mi = mi + 3;
    end else begin
      mi = mi - 9;
      t  = t + 1;
    end
    d = dd;
    m = mi;
    y = t;
  endfunction

  function automatic jdc_pkg::jdc_out_t calendar_convert(jdc_pkg::jdc_in_t a);
    jdc_pkg::jdc_out_t r;
    logic [31:0]       jd, d, m, y;
    r = '0;
    if (a.req_type == jdc_pkg::REQ_TO_JD) begin
      jd = days_from_date(32'(a.in_day), 32'(a.in_month), 32'(a.in_year));
      r.out_day_number = jd[22:0];
    end else if (a.in_day_number < jdc_pkg::JD_MIN || a.in_day_number > jdc_pkg::JD_MAX) begin
      r.out_of_range = 1'b1;
    end else begin
      date_from_days(32'(a.in_day_number), d, m, y);
      r.out_day   = d[4:0];
      r.out_month = m[3:0];
      r.out_year  = y[13:0];
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [22:0] want, logic [22:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    jdc_pkg::jdc_out_t want;
    if (rst) begin
      awaited_conversions.delete();
    end else begin
      if (req_valid && !req_stall) awaited_conversions.push_back(calendar_convert(req));
      if (rsp_valid && !rsp_stall) begin
        if (awaited_conversions.size() == 0) begin
          $error("rsp item with no request waiting");
          errs++;
        end else begin
          want = awaited_conversions.pop_front();
          check_field("out_day_number", want.out_day_number, rsp.out_day_number);
          check_field("out_day", 23'(want.out_day), 23'(rsp.out_day));
          check_field("out_month", 23'(want.out_month), 23'(rsp.out_month));
          check_field("out_year", 23'(want.out_year), 23'(rsp.out_year));
          check_field("out_of_range", 23'(want.out_of_range), 23'(rsp.out_of_range));
        end
      end
    end
    outstanding <= awaited_conversions.size();
    fail_count  <= errs;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench top: stimulus, flow control and verdict for the julian day converter
`timescale 1ns / 1ps

module tb_top;

  // stimulus sizes and windows
  localparam int N_RANDOM    = 1030;
  localparam int TX_CALM_LO  = 150;   // item window with no sender gaps
  localparam int TX_CALM_HI  = 450;
  localparam int PAUSE_AT    = 900;   // sender waits here until every result is back
  localparam int RX_CALM_LO  = 150;   // cycle window with no receiver stalls
  localparam int RX_CALM_HI  = 450;
  localparam int HOLD_START  = 700;   // long receiver hold-off, fills the pipeline
  localparam int HOLD_LEN    = 80;
  localparam int IDLE_PCT    = 6;
  localparam int TAIL_CYCLES = 24;    // idle tail after the final drain
  localparam int STUCK_LIMIT = 2000;  // cycles with nothing accepted on either side

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  jdc_pkg::jdc_in_t  req       = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  jdc_pkg::jdc_out_t rsp;

  int outstanding;
  int fail_count;
  int rx_cycle    = 0;
  int stuck_count = 0;

  jdc_pkg::jdc_in_t opening[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  julian_day_converter u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  jdc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // date to day number request, day number field left at zero
  function automatic jdc_pkg::jdc_in_t date_req(int d, int m, int y);
    jdc_pkg::jdc_in_t it;
    it          = '0;
    it.req_type = jdc_pkg::REQ_TO_JD;
    it.in_day   = 5'(d);
    it.in_month = 4'(m);
    it.in_year  = 14'(y);
    return it;
  endfunction

  // day number to date request, date fields left at zero
  function automatic jdc_pkg::jdc_in_t number_req(int unsigned jd);
    jdc_pkg::jdc_in_t it;
    it               = '0;
    it.req_type      = jdc_pkg::REQ_TO_DATE;
    it.in_day_number = 23'(jd);
    return it;
  endfunction

  // mostly well-formed requests; the field the block ignores is fully random
  function automatic jdc_pkg::jdc_in_t random_req();
    jdc_pkg::jdc_in_t it;
    int unsigned      pick;
    it.req_type      = ($urandom_range(0, 1) == 0) ? jdc_pkg::REQ_TO_JD : jdc_pkg::REQ_TO_DATE;
    it.in_day        = 5'($urandom_range(0, 31));
    it.in_month      = 4'($urandom_range(0, 15));
    it.in_year       = 14'($urandom_range(0, 16383));
    it.in_day_number = 23'($urandom_range(0, 8388607));
    pick             = $urandom_range(0, 99);
    if (it.req_type == jdc_pkg::REQ_TO_JD) begin
      // plain calendar dates, then a few odd months, days and years
      if (pick >= 8)  it.in_month = 4'($urandom_range(1, 12));
      if (pick >= 16) it.in_day   = 5'($urandom_range(1, 31));
      if (pick >= 24) it.in_year  = 14'($urandom_range(0, 9999));
      if (pick >= 24 && pick < 30) begin
        it.in_year = ($urandom_range(0, 1) == 0) ? 14'($urandom_range(0, 3))
                                                 : 14'($urandom_range(9996, 9999));
      end
    end else begin
      // in range most of the time, both out-of-range sides and the borders too
      if (pick < 8) begin
        it.in_day_number = 23'($urandom_range(0, jdc_pkg::JD_MIN - 1));
      end else if (pick < 16) begin
        it.in_day_number = 23'($urandom_range(jdc_pkg::JD_MAX + 1, 8388607));
      end else if (pick < 20) begin
        it.in_day_number = 23'($urandom_range(jdc_pkg::JD_MIN - 3, jdc_pkg::JD_MIN + 3));
      end else if (pick < 24) begin
        it.in_day_number = 23'($urandom_range(jdc_pkg::JD_MAX - 3, jdc_pkg::JD_MAX + 3));
      end else begin
        it.in_day_number = 23'($urandom_range(jdc_pkg::JD_MIN, jdc_pkg::JD_MAX));
      end
    end
    return it;
  endfunction

  // offer one item and hold it until the block takes it
  task automatic send_req(jdc_pkg::jdc_in_t it);
    req       <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // random sender gap, skipped inside the calm window
  task automatic maybe_idle(int idx);
    if ((idx < TX_CALM_LO || idx >= TX_CALM_HI) && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // receiver: random stalls, a calm stretch and one long hold-off that
  // backs the pipeline up into req_stall while the sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      rx_cycle  <= 0;
      rsp_stall <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
        rsp_stall <= 1'b1;
      end else if (rx_cycle >= RX_CALM_LO && rx_cycle < RX_CALM_HI) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // watchdog: nothing accepted on either channel for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      stuck_count <= 0;
    end else if (stuck_count >= STUCK_LIMIT) begin
      $display("** julian_day_converter: FAILED **");
      $finish;
    end else begin
      stuck_count <= stuck_count + 1;
    end
  end

  initial begin
    // forward extremes: year 0 clamp, first and last dates, leap days,
    // january/february path, month 0 and months above 12, field maxima and minima
    opening.push_back(date_req(1, 1, 0));
    opening.push_back(date_req(1, 1, 1));
    opening.push_back(date_req(31, 12, 9999));
    opening.push_back(date_req(29, 2, 2000));
    opening.push_back(date_req(28, 2, 1900));
    opening.push_back(date_req(1, 3, 2000));
    opening.push_back(date_req(31, 1, 2024));
    opening.push_back(date_req(15, 0, 2024));
    opening.push_back(date_req(1, 13, 2023));
    opening.push_back(date_req(31, 15, 16383));
    opening.push_back(date_req(0, 0, 0));
    // reverse: zero, both range borders from each side, field maximum, a few known days
    opening.push_back(number_req(0));
    opening.push_back(number_req(jdc_pkg::JD_MIN - 1));
    opening.push_back(number_req(jdc_pkg::JD_MIN));
    opening.push_back(number_req(jdc_pkg::JD_MAX));
    opening.push_back(number_req(jdc_pkg::JD_MAX + 1));
    opening.push_back(number_req(8388607));
    opening.push_back(number_req(2451545));
    opening.push_back(number_req(2451604));
    opening.push_back(number_req(2299161));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) begin
      maybe_idle(TX_CALM_HI);
      send_req(opening[i]);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == PAUSE_AT) drain();
      maybe_idle(i);
      send_req(random_req());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("** julian_day_converter: PASSED **");
    end else begin
      $display("** julian_day_converter: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/jdc_pkg.sv
hdl/jdc_fwd_path.sv
hdl/jdc_rev_path.sv
hdl/julian_day_converter.sv
tb/sv/jdc_checker.sv
tb/sv/tb_top.sv
